// File: hdl/bfd_pkg.sv
// Shared constants for the box filter RGB downscaler.
// No dependencies; imported by box_filter_rgb_downscale.
package bfd_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;

  localparam int unsigned SizeW  = 13;               // size / position register width
  localparam int unsigned ColW   = $clog2(MaxWidth); // column memory address width
  localparam int unsigned SumW   = 32;
  localparam int unsigned CntW   = 25;
  localparam int unsigned WordW  = 3 * SumW + CntW;
  localparam int unsigned QuotW  = 8;
  localparam int unsigned AddrW  = 4;

  localparam logic [1:0] RegSrcWidth  = 2'd0;
  localparam logic [1:0] RegSrcHeight = 2'd1;
  localparam logic [1:0] RegDstWidth  = 2'd2;
  localparam logic [1:0] RegDstHeight = 2'd3;

  localparam logic [SizeW-1:0] SizeReset = SizeW'(64);

endpackage

// File: hdl/box_filter_rgb_downscale.sv
// Box filter RGB downscaler: column accumulator memory, box end stepping, averaging divider.
// Depends on bfd_pkg.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  in      | in_valid_i/in_ready_o| in_red_i, in_green_i, in_blue_i
//  out     | out_valid_o/out_ready_i | out_red_o, out_green_o, out_blue_o, frame_end_o
//  cfg     | APB psel/penable     | paddr, pwdata, prdata (4 x 13-bit sizes)
//
// Each pixel reads its column entry and writes it back (registered RAM read).
// A pixel that closes a box then passes through the bit-per-cycle averaging
// divider and the load of the output register.
// Reset and every register write start a clearing pass over all 4096 entries of the column
// memory; no beat is taken meanwhile. A full output register stalls the block in S_HOLD.
module box_filter_rgb_downscale (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bfd_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  in_red_i,
  input  logic [7:0]                  in_green_i,
  input  logic [7:0]                  in_blue_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  out_red_o,
  output logic [7:0]                  out_green_o,
  output logic [7:0]                  out_blue_o,
  output logic                        frame_end_o
);
  import bfd_pkg::*;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_UPD, S_DIV, S_HOLD} state_e;

  state_e state_q;
  logic [SizeW-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [SizeW-1:0] sw, sh, dw, dh;

  // effective sizes
  always_comb begin
    sw = (src_w_q == '0) ? SizeW'(1) : (src_w_q > SizeW'(MaxWidth)) ? SizeW'(MaxWidth) : src_w_q;
    sh = (src_h_q == '0) ? SizeW'(1) :
         (src_h_q > SizeW'(MaxHeight)) ? SizeW'(MaxHeight) : src_h_q;
    dw = (dst_w_q == '0) ? SizeW'(1) : (dst_w_q > sw) ? sw : dst_w_q;
    dh = (dst_h_q == '0) ? SizeW'(1) : (dst_h_q > sh) ? sh : dst_h_q;
  end

  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      RegSrcWidth:  prdata = 32'(src_w_q);
      RegSrcHeight: prdata = 32'(src_h_q);
      RegDstWidth:  prdata = 32'(dst_w_q);
      RegDstHeight: prdata = 32'(dst_h_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SizeReset;
      src_h_q <= SizeReset;
      dst_w_q <= SizeReset;
      dst_h_q <= SizeReset;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegSrcWidth:  src_w_q <= pwdata[SizeW-1:0];
        RegSrcHeight: src_h_q <= pwdata[SizeW-1:0];
        RegDstWidth:  dst_w_q <= pwdata[SizeW-1:0];
        RegDstHeight: dst_h_q <= pwdata[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // step sizes of the box ends: s = q*d + r, one quotient bit a cycle
  logic [SizeW-1:0] cq_q, cr_q, rq_q, rr_q;
  logic [3:0]       sdiv_cnt_q;
  logic [SizeW:0]   ctry, rtry;

  assign ctry = {cr_q, cq_q[SizeW-1]};
  assign rtry = {rr_q, rq_q[SizeW-1]};

  // column memory: {red, green, blue sums, count}
  logic [WordW-1:0] mem [MaxWidth];
  logic [WordW-1:0] rd_q, wr_data;
  logic [ColW-1:0]  rd_addr, wr_addr;
  logic             wr_en;

  logic [ColW:0]    clr_cnt_q;
  logic [SizeW-1:0] sc_q, sr_q, ce_q, re_q, cacc_q, racc_q;
  logic [ColW-1:0]  oc_q;
  logic [SizeW-1:0] or_q;
  logic [7:0]       pr_q, pg_q, pb_q;

  // averaging divider
  logic [SumW-1:0]  rem_r_q, rem_g_q, rem_b_q;
  logic [SumW:0]    dv_q;
  logic [QuotW-1:0] q_r_q, q_g_q, q_b_q;
  logic [2:0]       bit_q;
  logic             fe_q;
  logic             gr, gg, gb;

  logic [7:0]       o_r_q, o_g_q, o_b_q;
  logic             o_fe_q, o_v_q;

  logic [SumW-1:0]  nr, ng, nb;
  logic [CntW-1:0]  ncnt;
  logic             col_last, row_last, emit;
  logic [SizeW:0]   cacc_sum, racc_sum;
  logic             sdiv_load, o_load;

  assign rd_addr = oc_q;
  assign nr   = rd_q[WordW-1 -: SumW] + SumW'(pr_q);
  assign ng   = rd_q[WordW-1-SumW -: SumW] + SumW'(pg_q);
  assign nb   = rd_q[CntW +: SumW] + SumW'(pb_q);
  assign ncnt = rd_q[CntW-1:0] + CntW'(1);
  assign col_last = ({1'b0, sc_q} + 14'd1) >= {1'b0, ce_q};
  assign row_last = ({1'b0, sr_q} + 14'd1) >= {1'b0, re_q};
  assign emit = col_last & row_last;
  assign cacc_sum = {1'b0, cacc_q} + {1'b0, cr_q};
  assign racc_sum = {1'b0, racc_q} + {1'b0, rr_q};

  // size divider (re)start and output register load
  assign sdiv_load = !cfg_wr && (state_q == S_CLEAR) && (clr_cnt_q == '0);
  assign o_load    = !cfg_wr && (state_q == S_HOLD) && (!o_v_q || out_ready_i);

  assign gr = {1'b0, rem_r_q} >= dv_q;
  assign gg = {1'b0, rem_g_q} >= dv_q;
  assign gb = {1'b0, rem_b_q} >= dv_q;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = oc_q;
    wr_data = '0;
    if (state_q == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_q[ColW-1:0];
    end else if (state_q == S_UPD) begin
      wr_en   = 1'b1;
      wr_data = emit ? '0 : {nr, ng, nb, ncnt};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = o_v_q;
  assign out_red_o   = o_r_q;
  assign out_green_o = o_g_q;
  assign out_blue_o  = o_b_q;
  assign frame_end_o = o_fe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_cnt_q  <= '0;
      sdiv_cnt_q <= '0;
      cq_q <= '0; cr_q <= '0; rq_q <= '0; rr_q <= '0;
      sc_q <= '0; sr_q <= '0; ce_q <= '0; re_q <= '0;
      cacc_q <= '0; racc_q <= '0; oc_q <= '0; or_q <= '0;
      bit_q <= '0; o_v_q <= 1'b0;
    end else begin
      if (o_v_q && out_ready_i && !o_load) begin
        o_v_q <= 1'b0;
      end
      if (sdiv_cnt_q != '0 && !sdiv_load) begin
        sdiv_cnt_q <= sdiv_cnt_q - 4'd1;
        if (ctry >= {1'b0, dw}) begin
          cr_q <= SizeW'(ctry - {1'b0, dw});
          cq_q <= {cq_q[SizeW-2:0], 1'b1};
        end else begin
          cr_q <= ctry[SizeW-1:0];
          cq_q <= {cq_q[SizeW-2:0], 1'b0};
        end
        if (rtry >= {1'b0, dh}) begin
          rr_q <= SizeW'(rtry - {1'b0, dh});
          rq_q <= {rq_q[SizeW-2:0], 1'b1};
        end else begin
          rr_q <= rtry[SizeW-1:0];
          rq_q <= {rq_q[SizeW-2:0], 1'b0};
        end
      end
      if (cfg_wr) begin
        state_q   <= S_CLEAR;
        clr_cnt_q <= '0;
      end else begin
        case (state_q)
          S_CLEAR: begin
            if (clr_cnt_q == '0) begin
              cq_q <= sw; cr_q <= '0;
              rq_q <= sh; rr_q <= '0;
              sdiv_cnt_q <= 4'(SizeW);
            end
            clr_cnt_q <= clr_cnt_q + 1'b1;
            if (clr_cnt_q == (ColW+1)'(MaxWidth - 1)) begin
              state_q <= S_IDLE;
              sc_q <= '0; sr_q <= '0; oc_q <= '0; or_q <= '0;
              ce_q <= cq_q; re_q <= rq_q; cacc_q <= cr_q; racc_q <= rr_q;
            end
          end
          S_IDLE: begin
            if (in_valid_i) begin
              pr_q <= in_red_i; pg_q <= in_green_i; pb_q <= in_blue_i;
              state_q <= S_UPD;
            end
          end
          S_UPD: begin
            if (emit) begin
              rem_r_q <= nr; rem_g_q <= ng; rem_b_q <= nb;
              dv_q    <= {1'b0, ncnt, 7'd0};
              bit_q   <= 3'd7;
              fe_q    <= (({1'b0, or_q} + 14'd1) >= {1'b0, dh}) &&
                         (({2'b0, oc_q} + 14'd1) >= {1'b0, dw});
              state_q <= S_DIV;
            end else begin
              state_q <= S_IDLE;
            end
            if (({1'b0, sc_q} + 14'd1) >= {1'b0, sw}) begin
              sc_q <= '0; oc_q <= '0; ce_q <= cq_q; cacc_q <= cr_q;
              if (({1'b0, sr_q} + 14'd1) >= {1'b0, sh}) begin
                sr_q <= '0; or_q <= '0; re_q <= rq_q; racc_q <= rr_q;
              end else begin
                sr_q <= sr_q + 1'b1;
                if (row_last) begin
                  or_q <= or_q + 1'b1;
                  if (racc_sum >= {1'b0, dh}) begin
                    racc_q <= SizeW'(racc_sum - {1'b0, dh});
                    re_q   <= re_q + rq_q + 1'b1;
                  end else begin
                    racc_q <= racc_sum[SizeW-1:0];
                    re_q   <= re_q + rq_q;
                  end
                end
              end
            end else begin
              sc_q <= sc_q + 1'b1;
              if (col_last) begin
                oc_q <= oc_q + 1'b1;
                if (cacc_sum >= {1'b0, dw}) begin
                  cacc_q <= SizeW'(cacc_sum - {1'b0, dw});
                  ce_q   <= ce_q + cq_q + 1'b1;
                end else begin
                  cacc_q <= cacc_sum[SizeW-1:0];
                  ce_q   <= ce_q + cq_q;
                end
              end
            end
          end
          S_DIV: begin
            q_r_q <= {q_r_q[QuotW-2:0], gr};
            q_g_q <= {q_g_q[QuotW-2:0], gg};
            q_b_q <= {q_b_q[QuotW-2:0], gb};
            if (gr) rem_r_q <= SumW'({1'b0, rem_r_q} - dv_q);
            if (gg) rem_g_q <= SumW'({1'b0, rem_g_q} - dv_q);
            if (gb) rem_b_q <= SumW'({1'b0, rem_b_q} - dv_q);
            dv_q  <= dv_q >> 1;
            bit_q <= bit_q - 3'd1;
            if (bit_q == '0) begin
              state_q <= S_HOLD;
            end
          end
          S_HOLD: begin
            if (o_load) begin
              o_r_q  <= q_r_q; o_g_q <= q_g_q; o_b_q <= q_b_q;
              o_fe_q <= fe_q;
              o_v_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          end
          default: state_q <= S_CLEAR;
        endcase
      end
    end
  end

endmodule
